// File: src/wsm_pkg.sv
// ----------------------------------------------------------------------------
// wsm_pkg
// Shared constants, types and controller/datapath interface structs for the
// windowed score maximum block.
// ----------------------------------------------------------------------------
package wsm_pkg;

	localparam int MAX_WINDOW    = 64;
	localparam int NUM_CLASSES   = 4;
	localparam int SCORE_BITS    = 16;

	localparam int PTR_BITS      = $clog2(MAX_WINDOW);
	localparam int LEN_BITS      = $clog2(MAX_WINDOW + 1);
	localparam int REM_BITS      = $clog2(MAX_WINDOW);
	localparam int CLS_BITS      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int SUM_BITS      = 32;
	localparam int DIV_BITS      = SUM_BITS + 1;
	localparam int RES_BITS      = DIV_BITS + 1;
	localparam int DCNT_BITS     = $clog2(DIV_BITS);
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam int PRIOR_BITS    = 16;

	localparam logic [LEN_BITS-1:0] WINDOW_LEN_RST = LEN_BITS'(30);

	localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LEN = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_PRIOR_0    = CFG_IDX_BITS'(1);

	typedef logic signed [SCORE_BITS-1:0] score_t;
	typedef logic signed [SUM_BITS-1:0]   sum_t;
	typedef logic signed [PRIOR_BITS-1:0] prior_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_CMP,
		ST_DIV_LOAD,
		ST_DIV_RUN,
		ST_OUT_WAIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic update;
		logic compare;
		logic div_start;
		logic store_res;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic short_trk;
		logic div_done;
		logic cls_last;
	} stat_t;

endpackage

// File: src/wsm_div.sv
// ----------------------------------------------------------------------------
// wsm_div
// Unsigned restoring divider, one quotient bit per cycle, for dividing a
// window sum magnitude by the window length.
// ----------------------------------------------------------------------------
module wsm_div import wsm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIV_BITS-1:0] dividend,
	input  logic [LEN_BITS-1:0] divisor,
	output logic                done,
	output logic [DIV_BITS-1:0] quot
);

	logic                 busy_q;
	logic                 done_q;
	logic [DCNT_BITS-1:0] cnt_q;
	logic [REM_BITS-1:0]  rem_q;
	logic [DIV_BITS-1:0]  quot_q;

	logic [REM_BITS:0]    rem_sh;
	logic [REM_BITS+1:0]  trial;
	logic                 ge;

	always_comb begin
		rem_sh = {rem_q, quot_q[DIV_BITS-1]};
		trial  = {1'b0, rem_sh} - (REM_BITS+2)'(divisor);
		ge     = ~trial[REM_BITS+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_BITS'(DIV_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
		end else if (busy_q) begin
			rem_q  <= ge ? trial[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
			quot_q <= {quot_q[DIV_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// File: src/wsm_dpath.sv
// ----------------------------------------------------------------------------
// wsm_dpath
// Datapath: configuration registers, history ring, per-class window sums and
// maxima, floor division by window length and saturated result registers.
// ----------------------------------------------------------------------------
module wsm_dpath import wsm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  score_t                   score [NUM_CLASSES],
	input  logic                     last_item,
	input  cmd_t                     cmd,
	output stat_t                    stat,
	output score_t                   best [NUM_CLASSES],
	output logic                     too_short
);

	localparam int RING_W = NUM_CLASSES * SCORE_BITS;
	localparam logic signed [RES_BITS:0] TOT_MAX = (RES_BITS+1)'(2**(SCORE_BITS-1) - 1);
	localparam logic signed [RES_BITS:0] TOT_MIN = -TOT_MAX - 1;

	logic [LEN_BITS-1:0]  window_len_q;
	prior_t               prior_q [NUM_CLASSES];

	logic [RING_W-1:0]    ring_mem [MAX_WINDOW];
	logic [RING_W-1:0]    ring_rd_q;
	logic [RING_W-1:0]    ring_wr;

	score_t               score_q [NUM_CLASSES];
	logic                 last_q;
	logic                 drop_q;
	logic [PTR_BITS-1:0]  ptr_q;
	logic [LEN_BITS-1:0]  seen_q;
	sum_t                 sum_q [NUM_CLASSES];
	sum_t                 best_q [NUM_CLASSES];
	logic [CLS_BITS-1:0]  cls_q;
	score_t               res_q [NUM_CLASSES];
	score_t               best_out_q [NUM_CLASSES];
	logic                 too_short_q;

	logic [LEN_BITS-1:0]  eff_len;
	logic [PTR_BITS-1:0]  old_pos;
	logic [CLS_BITS-1:0]  prior_sel;
	logic                 cls_last;
	sum_t                 sel_best;
	logic                 neg;
	logic [DIV_BITS-1:0]  ext;
	logic [DIV_BITS-1:0]  mag;
	logic [DIV_BITS-1:0]  quot;
	logic                 div_done;
	logic signed [RES_BITS-1:0] qs;
	logic signed [RES_BITS:0]   tot;
	score_t               sat;

	// config registers
	assign prior_sel = CLS_BITS'(cfg_index - REG_PRIOR_0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WINDOW_LEN_RST;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				prior_q[c] <= '0;
			end
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_WINDOW_LEN: window_len_q <= cfg_data[LEN_BITS-1:0];
				default: begin
					if (cfg_index >= REG_PRIOR_0 &&
					    cfg_index < REG_PRIOR_0 + CFG_IDX_BITS'(NUM_CLASSES)) begin
						prior_q[prior_sel] <= cfg_data[PRIOR_BITS-1:0];
					end
				end
			endcase
		end
	end

	always_comb begin
		if (window_len_q == '0) begin
			eff_len = LEN_BITS'(1);
		end else if (window_len_q > LEN_BITS'(MAX_WINDOW)) begin
			eff_len = LEN_BITS'(MAX_WINDOW);
		end else begin
			eff_len = window_len_q;
		end
	end

	assign old_pos = ptr_q - eff_len[PTR_BITS-1:0];

	// history ring, read-first
	always_comb begin
		for (int c = 0; c < NUM_CLASSES; c++) begin
			ring_wr[c*SCORE_BITS +: SCORE_BITS] = score[c];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ring_mem[ptr_q] <= ring_wr;
			ring_rd_q       <= ring_mem[old_pos];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			score_q <= score;
		end
	end

	// track state
	assign cls_last = (cls_q == CLS_BITS'(NUM_CLASSES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
			drop_q <= 1'b0;
			ptr_q  <= '0;
			seen_q <= '0;
			cls_q  <= '0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				sum_q[c]  <= '0;
				best_q[c] <= {1'b1, {(SUM_BITS-1){1'b0}}};
			end
		end else if (cmd.load_out) begin
			ptr_q  <= '0;
			seen_q <= '0;
			cls_q  <= '0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				sum_q[c]  <= '0;
				best_q[c] <= {1'b1, {(SUM_BITS-1){1'b0}}};
			end
		end else begin
			if (cmd.accept) begin
				ptr_q  <= ptr_q + 1'b1;
				last_q <= last_item;
				drop_q <= (seen_q >= eff_len);
				if (seen_q < LEN_BITS'(MAX_WINDOW)) begin
					seen_q <= seen_q + 1'b1;
				end
			end
			if (cmd.update) begin
				for (int c = 0; c < NUM_CLASSES; c++) begin
					sum_q[c] <= sum_q[c] + sum_t'(score_q[c]) -
					            (drop_q ? sum_t'(score_t'(ring_rd_q[c*SCORE_BITS +: SCORE_BITS]))
					                    : sum_t'(0));
				end
			end
			if (cmd.compare && seen_q >= eff_len) begin
				for (int c = 0; c < NUM_CLASSES; c++) begin
					if (sum_q[c] > best_q[c]) begin
						best_q[c] <= sum_q[c];
					end
				end
			end
			if (cmd.store_res) begin
				cls_q <= cls_last ? '0 : cls_q + 1'b1;
			end
		end
	end

	// floor division through magnitude: negative sums divide |s| + len - 1
	always_comb begin
		sel_best = best_q[cls_q];
		neg      = sel_best[SUM_BITS-1];
		ext      = DIV_BITS'(sel_best);
		mag      = neg ? (~ext + 1'b1 + DIV_BITS'(eff_len - 1'b1)) : ext;
	end

	wsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (mag),
		.divisor  (eff_len),
		.done     (div_done),
		.quot     (quot)
	);

	always_comb begin
		qs  = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
		tot = (RES_BITS+1)'(qs) + (RES_BITS+1)'(prior_q[cls_q]);
		if (tot > TOT_MAX) begin
			sat = score_t'(TOT_MAX);
		end else if (tot < TOT_MIN) begin
			sat = score_t'(TOT_MIN);
		end else begin
			sat = score_t'(tot);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_res) begin
			res_q[cls_q] <= sat;
		end
	end

	// output registers
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			too_short_q <= (seen_q < eff_len);
			for (int c = 0; c < NUM_CLASSES; c++) begin
				best_out_q[c] <= (seen_q < eff_len) ? score_t'(0) : res_q[c];
			end
		end
	end

	assign stat.last      = last_q;
	assign stat.short_trk = (seen_q < eff_len);
	assign stat.div_done  = div_done;
	assign stat.cls_last  = cls_last;

	assign best      = best_out_q;
	assign too_short = too_short_q;

endmodule

// File: src/wsm_ctrl.sv
// ----------------------------------------------------------------------------
// wsm_ctrl
// Controller: sequences accept, sum update, maximum tracking, per-class
// division and result hand-off, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module wsm_ctrl import wsm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = ST_CMP;
			end
			ST_CMP: begin
				cmd.compare = 1'b1;
				if (!stat.last) begin
					state_d = ST_IDLE;
				end else if (stat.short_trk) begin
					state_d = ST_OUT_WAIT;
				end else begin
					state_d = ST_DIV_LOAD;
				end
			end
			ST_DIV_LOAD: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				if (stat.div_done) begin
					cmd.store_res = 1'b1;
					state_d       = stat.cls_last ? ST_OUT_WAIT : ST_DIV_LOAD;
				end
			end
			ST_OUT_WAIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: src/windowed_score_max.sv
// ----------------------------------------------------------------------------
// windowed_score_max
// Best moving-average class score over a track of per-frame score vectors.
//
// Input channel (in_valid/in_ready): one beat per frame carrying four signed
// Q8.8 scores and last_item. Output channel (out_valid/out_ready): one beat
// per track, sent after the beat with last_item set, carrying per class the
// prior plus floor(largest window sum / window_len), saturated, or too_short
// with zero scores when the track was shorter than window_len.
// Each frame passes accept with the ring read, sum update and maximum
// update in turn. The last frame of a track adds four divisions on one
// shared radix-2 divider, one per class, unless the track is too short.
// The result sits in an output register; frames of the next track are taken
// while it waits, and the output side holds only when a second result is ready
// before the first one has been taken.
// Config writes (cfg_wr_en/cfg_index/cfg_data) take effect at once: index 0
// window_len, 1..4 prior_0..prior_3. Reset clears all track state and sets
// window_len to 30 and every prior to zero; the history ring needs no clear.
// ----------------------------------------------------------------------------
module windowed_score_max import wsm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [15:0]       score_0,
	input  logic signed [15:0]       score_1,
	input  logic signed [15:0]       score_2,
	input  logic signed [15:0]       score_3,
	input  logic                     last_item,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [15:0]       best_0,
	output logic signed [15:0]       best_1,
	output logic signed [15:0]       best_2,
	output logic signed [15:0]       best_3,
	output logic                     too_short,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	score_t score [NUM_CLASSES];
	score_t best  [NUM_CLASSES];
	cmd_t   cmd;
	stat_t  stat;

	assign score[0] = score_0;
	assign score[1] = score_1;
	assign score[2] = score_2;
	assign score[3] = score_3;

	wsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	wsm_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.score     (score),
		.last_item (last_item),
		.cmd       (cmd),
		.stat      (stat),
		.best      (best),
		.too_short (too_short)
	);

	assign best_0 = best[0];
	assign best_1 = best[1];
	assign best_2 = best[2];
	assign best_3 = best[3];

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for windowed_score_max. Score tracks go in over the
// input channel and the best windowed average of each track comes back over
// the output channel. A scoreboard class keeps its own copy of the window
// sums, the best sums and the register values, and predicts each result
// when the last frame of a track is accepted. A short directed part covers
// the reset settings, score and prior extremes, saturation, floor rounding,
// zero window length and too-short tracks. Randomized phases follow, each
// with fresh register values and with window lengths up to and past the
// ring depth. Both sides idle at random. One long output stall fills the
// block, and the registers are only rewritten once the block has drained.
// ----------------------------------------------------------------------------
module tb_top import wsm_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES  = 200;
	localparam int HOLD_CYCLES    = 600;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_FRAMES   = 100;

	typedef logic [NUM_CLASSES-1:0][SCORE_BITS-1:0] frame_scores_t;
	typedef logic [NUM_CLASSES-1:0][PRIOR_BITS-1:0] prior_vec_t;

	typedef struct packed {
		logic                                   too_short;
		logic [NUM_CLASSES-1:0][SCORE_BITS-1:0] best;
	} track_result_t;

	class best_avg_model;
		longint        win_sum [NUM_CLASSES];
		longint        peak_sum [NUM_CLASSES];
		longint        ring [MAX_WINDOW][NUM_CLASSES];
		longint        prior [NUM_CLASSES];
		int            frames_in_track;
		int            wr_ptr;
		int            win_len;
		track_result_t expected_best [$];
		int            mismatches;
		int            frames_noted;
		int            tracks_noted;
		int            results_checked;
		int            short_results;

		function new();
			win_len         = 30;
			mismatches      = 0;
			frames_noted    = 0;
			tracks_noted    = 0;
			results_checked = 0;
			short_results   = 0;
			for (int c = 0; c < NUM_CLASSES; c++)
				prior[c] = 0;
			clear_track();
		endfunction

		function void clear_track();
			for (int c = 0; c < NUM_CLASSES; c++) begin
				win_sum[c]  = 0;
				peak_sum[c] = 64'sh8000_0000_0000_0000;
			end
			frames_in_track = 0;
			wr_ptr          = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
			if (idx == REG_WINDOW_LEN)
				win_len = int'(data[6:0]);
			else if (idx >= REG_PRIOR_0 && idx < REG_PRIOR_0 + NUM_CLASSES)
				prior[idx - REG_PRIOR_0] = longint'($signed(data[PRIOR_BITS-1:0]));
		endfunction

		function void note_frame(frame_scores_t s, bit is_last);
			int            eff;
			int            old_pos;
			bit            drop;
			longint        x;
			longint        q;
			longint        r;
			track_result_t res;

			eff     = (win_len < 1) ? 1 : (win_len > MAX_WINDOW) ? MAX_WINDOW : win_len;
			old_pos = (wr_ptr + MAX_WINDOW - eff) % MAX_WINDOW;
			drop    = frames_in_track >= eff;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				x = longint'($signed(s[c]));
				win_sum[c] += x;
				if (drop)
					win_sum[c] -= ring[old_pos][c];
				ring[wr_ptr][c] = x;
			end
			wr_ptr = (wr_ptr + 1) % MAX_WINDOW;
			if (frames_in_track < MAX_WINDOW)
				frames_in_track++;
			if (frames_in_track >= eff)
				for (int c = 0; c < NUM_CLASSES; c++)
					if (win_sum[c] > peak_sum[c])
						peak_sum[c] = win_sum[c];
			frames_noted++;
			if (!is_last)
				return;

			tracks_noted++;
			res = '0;
			if (frames_in_track < eff) begin
				res.too_short = 1'b1;
			end else begin
				for (int c = 0; c < NUM_CLASSES; c++) begin
					q = peak_sum[c] / longint'(eff);
					if ((peak_sum[c] % longint'(eff)) != 0 && peak_sum[c] < 0)
						q--;
					if (q > (longint'(1) << 40))
						q = longint'(1) << 40;
					if (q < -(longint'(1) << 40))
						q = -(longint'(1) << 40);
					r = q + prior[c];
					if (r > 32767)
						r = 32767;
					if (r < -32768)
						r = -32768;
					res.best[c] = r[SCORE_BITS-1:0];
				end
			end
			expected_best.insert(expected_best.size(), res);
			clear_track();
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			if (mismatches <= 100)
				$display("[%0t] mismatch: %s", $time, msg);
		endtask

		task check_result(track_result_t got);
			track_result_t want;
			if (expected_best.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing expected (too_short=%0b)",
					got.too_short));
				return;
			end
			want = expected_best.pop_front();
			results_checked++;
			if (want.too_short)
				short_results++;
			if (got.too_short !== want.too_short)
				report_mismatch($sformatf("result %0d too_short: got %0b, want %0b",
					results_checked, got.too_short, want.too_short));
			for (int c = 0; c < NUM_CLASSES; c++)
				if (got.best[c] !== want.best[c])
					report_mismatch($sformatf("result %0d best_%0d: got %0d, want %0d",
						results_checked, c, $signed(got.best[c]), $signed(want.best[c])));
		endtask
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [15:0]       score_0;
	logic signed [15:0]       score_1;
	logic signed [15:0]       score_2;
	logic signed [15:0]       score_3;
	logic                     last_item;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [15:0]       best_0;
	logic signed [15:0]       best_1;
	logic signed [15:0]       best_2;
	logic signed [15:0]       best_3;
	logic                     too_short;
	logic                     cfg_wr_en;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	best_avg_model best_avg = new();
	bit            idle_on  = 1'b1;
	bit            hold_req = 1'b0;
	int            settings_applied = 0;

	windowed_score_max DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.score_0   (score_0),
		.score_1   (score_1),
		.score_2   (score_2),
		.score_3   (score_3),
		.last_item (last_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.best_0    (best_0),
		.best_1    (best_1),
		.best_2    (best_2),
		.best_3    (best_3),
		.too_short (too_short),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic frame_scores_t frame_of(int s0, int s1, int s2, int s3);
		frame_scores_t f;
		f[0] = 16'(s0);
		f[1] = 16'(s1);
		f[2] = 16'(s2);
		f[3] = 16'(s3);
		return f;
	endfunction

	function automatic logic [15:0] rand_score();
		case ($urandom_range(0, 9))
			0:       return 16'h7fff;
			1:       return 16'h8000;
			2, 3:    return 16'($urandom_range(0, 1023)) - 16'd512;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [15:0] rand_prior();
		case ($urandom_range(0, 4))
			0:       return 16'h7fff;
			1:       return 16'h8000;
			2:       return 16'h0000;
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic send_frame(input frame_scores_t s, input bit is_last);
		int gap;
		gap = idle_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		score_0   <= s[0];
		score_1   <= s[1];
		score_2   <= s[2];
		score_3   <= s[3];
		last_item <= is_last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		best_avg.note_frame(s, is_last);
	endtask

	task automatic send_track(input int len);
		frame_scores_t s;
		for (int i = 0; i < len; i++) begin
			for (int c = 0; c < NUM_CLASSES; c++)
				s[c] = rand_score();
			send_frame(s, i == len - 1);
		end
	endtask

	// block is idle once every result is back and the last division is done
	task automatic settle();
		in_valid <= 1'b0;
		while (best_avg.expected_best.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		best_avg.write_reg(idx, data);
	endtask

	task automatic apply_setting(input int wl, input prior_vec_t p);
		write_reg(REG_WINDOW_LEN, 16'(wl));
		for (int c = 0; c < NUM_CLASSES; c++)
			write_reg(REG_PRIOR_0 + CFG_IDX_BITS'(c), p[c]);
		cfg_wr_en <= 1'b0;
		settings_applied++;
	endtask

	// receiver: random ready gaps, one long hold when asked
	initial begin : result_sink
		int            gap;
		track_result_t got;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = idle_on ? $urandom_range(0, 12) : 0;
			if (hold_req) begin
				hold_req = 1'b0;
				gap      = HOLD_CYCLES;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			got.too_short = too_short;
			got.best[0]   = best_0;
			got.best[1]   = best_1;
			got.best[2]   = best_2;
			got.best[3]   = best_3;
			best_avg.check_result(got);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[%0t] watchdog: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin : stimulus
		int         lens [10];
		int         eff;
		int         len;
		int         phase_frames;
		prior_vec_t priors;
		frame_scores_t s;

		lens = '{2, 64, 5, 127, 1, 100, 8, 3, 16, 4};
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		score_0   <= '0;
		score_1   <= '0;
		score_2   <= '0;
		score_3   <= '0;
		last_item <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window length of 30 makes a single frame too short
		send_frame(frame_of(32767, -32768, 1, -1), 1'b1);
		settle();

		// window of one with extreme priors: saturation both ways
		apply_setting(1, {16'hffff, 16'h0000, 16'h8000, 16'h7fff});
		send_frame(frame_of(32767, -32768, 0, -1), 1'b0);
		send_frame(frame_of(-32768, 32767, 1, 0), 1'b1);
		send_frame(frame_of(-32768, -32768, -32768, -32768), 1'b1);
		settle();

		// zero window length behaves as one
		apply_setting(0, {16'h0100, 16'hff00, 16'h0001, 16'h0000});
		send_frame(frame_of(-5, 7, 32767, -32768), 1'b0);
		send_frame(frame_of(3, -9, 32767, -32768), 1'b1);
		settle();

		// window of three: too short, exactly full with floor rounding, longer
		apply_setting(3, '0);
		send_track(2);
		send_frame(frame_of(-1, -2, 1, 100), 1'b0);
		send_frame(frame_of(-1, -2, 1, -101), 1'b0);
		send_frame(frame_of(0, -1, 0, 2), 1'b1);
		send_track(5);
		settle();

		for (int p = 0; p < 10; p++) begin
			for (int c = 0; c < NUM_CLASSES; c++)
				priors[c] = rand_prior();
			apply_setting(lens[p], priors);
			eff = (lens[p] < 1) ? 1 : (lens[p] > MAX_WINDOW) ? MAX_WINDOW : lens[p];
			if (p == 4) begin
				// long output hold while one-frame tracks keep coming
				hold_req = 1'b1;
				idle_on  = 1'b0;
				for (int i = 0; i < 24; i++) begin
					for (int c = 0; c < NUM_CLASSES; c++)
						s[c] = rand_score();
					send_frame(s, 1'b1);
				end
			end
			phase_frames = 0;
			while (phase_frames < PHASE_FRAMES) begin
				idle_on = ($urandom_range(0, 3) != 0);
				if (eff == 1 || $urandom_range(0, 9) < 7)
					len = eff + $urandom_range(0, 12);
				else
					len = $urandom_range(1, eff - 1);
				send_track(len);
				phase_frames += len;
			end
			idle_on = 1'b1;
			settle();
		end

		$display("summary: %0d frames in %0d tracks, %0d results checked (%0d too short)",
			best_avg.frames_noted, best_avg.tracks_noted, best_avg.results_checked,
			best_avg.short_results);
		$display("summary: %0d register settings, window lengths 0 to 127, one long output hold",
			settings_applied);
		if (best_avg.mismatches == 0 && best_avg.expected_best.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
